// ===== hdl/pcm_downmix_linear_upsampler_unit_macros.svh =====
// Assertion macros for the PCM downmix linear upsampler checker.
// Each macro expands to one labeled concurrent assertion on clk, disabled in reset.
`ifndef PCM_DOWNMIX_LINEAR_UPSAMPLER_UNIT_MACROS_SVH
`define PCM_DOWNMIX_LINEAR_UPSAMPLER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PDLU_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PDLU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pdlu_pkg.sv =====
// Shared types and constants for the PCM downmix linear upsampler.
// Used by the front, queue and back modules and the top level.
package pdlu_pkg;

  localparam int MAX_RATIO   = 8;
  localparam int REM_W       = $clog2(MAX_RATIO);
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [15:0] sample_t;
  typedef logic signed [16:0] step_t;

  typedef struct packed {
    sample_t               held;
    sample_t               mono;
    step_t                 step_q;
    logic [REM_W-1:0]      step_r;
    logic                  interp;
    logic                  last;
  } queue_entry_t;

endpackage

// ===== hdl/pcm_downmix_linear_upsampler_unit.sv =====
// Top level of the PCM downmix linear upsampler.
// Instantiates pdlu_front, pdlu_queue and pdlu_back; depends on pdlu_pkg.
//
// Takes one PCM frame per beat, downmixes it to mono when channel_count is two or three,
// and emits UPSAMPLE_RATIO linearly interpolated beats from the previous sample toward the
// new one, plus UPSAMPLE_RATIO copies of the final sample on a packet's last frame. The
// back stage produces one output beat per clock while the queue is not empty and the
// output is not stalled. The first frame of a packet that is not also its last yields
// nothing. Frames enter the front register at one per clock while the four-entry queue
// has room, and each frame passes through the front register, a queue slot and the
// output register before its first output beat appears. There is no clearing pass
// after reset.
module pcm_downmix_linear_upsampler_unit #(
  parameter int UPSAMPLE_RATIO = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] left_sample,
  input  logic signed [15:0] right_sample,
  input  logic               packet_last,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sample,
  output logic               run_last,
  output logic               packet_end
);

  pdlu_pkg::queue_entry_t entry;
  pdlu_pkg::queue_entry_t head;
  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;

  pdlu_front #(.UPSAMPLE_RATIO(UPSAMPLE_RATIO)) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .left_sample  (left_sample),
    .right_sample (right_sample),
    .packet_last  (packet_last),
    .push         (push),
    .entry        (entry),
    .full         (full)
  );

  pdlu_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .entry (entry),
    .full  (full),
    .pop   (pop),
    .head  (head),
    .empty (empty)
  );

  pdlu_back #(.UPSAMPLE_RATIO(UPSAMPLE_RATIO)) u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .run_last   (run_last),
    .packet_end (packet_end)
  );

endmodule

// ===== hdl/pdlu_front.sv =====
// Input stage: configuration register, downmix, held sample and step split.
// Depends on pdlu_pkg; pushes one entry per item that yields beats.
module pdlu_front #(
  parameter int UPSAMPLE_RATIO = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [15:0]     left_sample,
  input  logic signed [15:0]     right_sample,
  input  logic                   packet_last,
  output logic                   push,
  output pdlu_pkg::queue_entry_t entry,
  input  logic                   full
);

  localparam int RECIP_K = 20;
  localparam logic [RECIP_K-1:0] RECIP_M =
    RECIP_K'((2 ** RECIP_K + UPSAMPLE_RATIO - 1) / UPSAMPLE_RATIO);
  localparam logic [pdlu_pkg::REM_W:0] RATIO_C = (pdlu_pkg::REM_W + 1)'(UPSAMPLE_RATIO);

  logic [1:0]        channel_count;
  pdlu_pkg::sample_t held;
  logic              held_valid;
  logic              a_valid;
  pdlu_pkg::sample_t a_held;
  pdlu_pkg::sample_t a_mono;
  logic              a_interp;
  logic              a_last;

  logic [16:0]               sum;
  logic [16:0]               sum_adj;
  pdlu_pkg::sample_t         mono_in;
  logic [16:0]               diff;
  logic [16:0]               diff_mag;
  logic [35:0]               prod;
  logic [15:0]               q_mag;
  logic [19:0]               r_full;
  logic [pdlu_pkg::REM_W-1:0] r_mag;
  logic                      need_push;
  logic                      a_done;
  logic                      accept;

  always_comb begin
    sum     = {left_sample[15], left_sample} + {right_sample[15], right_sample};
    sum_adj = sum + {16'b0, sum[16]};
    mono_in = channel_count[1] ? pdlu_pkg::sample_t'(sum_adj[16:1]) : left_sample;
  end

  always_comb begin
    diff     = {a_mono[15], a_mono} - {a_held[15], a_held};
    diff_mag = diff[16] ? (17'd0 - diff) : diff;
    prod     = 36'(diff_mag[15:0]) * 36'(RECIP_M);
    q_mag    = prod[35:RECIP_K];
    r_full   = 20'(diff_mag[15:0]) - 20'(q_mag) * 20'(UPSAMPLE_RATIO);
    r_mag    = r_full[pdlu_pkg::REM_W-1:0];
    entry.held   = a_held;
    entry.mono   = a_mono;
    entry.interp = a_interp;
    entry.last   = a_last;
    if (!diff[16]) begin
      entry.step_q = pdlu_pkg::step_t'({1'b0, q_mag});
      entry.step_r = r_mag;
    end else if (r_mag == '0) begin
      entry.step_q = pdlu_pkg::step_t'(17'd0 - {1'b0, q_mag});
      entry.step_r = '0;
    end else begin
      entry.step_q = pdlu_pkg::step_t'(17'd0 - {1'b0, q_mag} - 17'd1);
      entry.step_r = pdlu_pkg::REM_W'(RATIO_C - {1'b0, r_mag});
    end
  end

  assign need_push = a_interp | a_last;
  assign a_done    = a_valid & (~need_push | ~full);
  assign in_stall  = a_valid & ~a_done;
  assign push      = a_valid & need_push & ~full;
  assign accept    = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= 2'd1;
      held_valid    <= 1'b0;
      a_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        channel_count <= cfg_data;
      end
      if (accept) begin
        a_valid    <= 1'b1;
        held_valid <= ~packet_last;
      end else if (a_done) begin
        a_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held     <= mono_in;
      a_held   <= held;
      a_mono   <= mono_in;
      a_interp <= held_valid;
      a_last   <= packet_last;
    end
  end

endmodule

// ===== hdl/pdlu_queue.sv =====
// Short queue of work entries between the front and back stages.
// Depends on pdlu_pkg for the entry type and depth.
module pdlu_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  pdlu_pkg::queue_entry_t entry,
  output logic                   full,
  input  logic                   pop,
  output pdlu_pkg::queue_entry_t head,
  output logic                   empty
);

  localparam int PTR_W = $clog2(pdlu_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(pdlu_pkg::QUEUE_DEPTH + 1);

  pdlu_pkg::queue_entry_t slots [pdlu_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_ptr;
  logic [PTR_W-1:0]       rd_ptr;
  logic [CNT_W-1:0]       count;

  assign full  = (count == CNT_W'(pdlu_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= entry;
    end
  end

endmodule

// ===== hdl/pdlu_back.sv =====
// Output sequencer: walks interpolation and trailing copies, one beat a cycle unless out_stall or empty.
// Depends on pdlu_pkg; reads the queue head and drives the output register.
module pdlu_back #(
  parameter int UPSAMPLE_RATIO = 6
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   empty,
  input  pdlu_pkg::queue_entry_t head,
  output logic                   pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [15:0]     out_sample,
  output logic                   run_last,
  output logic                   packet_end
);

  localparam int CW = (UPSAMPLE_RATIO > 2) ? $clog2(UPSAMPLE_RATIO) : 1;
  localparam logic [pdlu_pkg::REM_W:0] RATIO_C = (pdlu_pkg::REM_W + 1)'(UPSAMPLE_RATIO);

  typedef enum logic {PH_INTERP, PH_COPY} phase_t;

  logic                       started;
  phase_t                     phase;
  logic [CW-1:0]              cnt;
  pdlu_pkg::step_t            q;
  logic [pdlu_pkg::REM_W-1:0] r;

  phase_t                     cur_phase;
  logic [CW-1:0]              cur_cnt;
  pdlu_pkg::step_t            cur_q;
  logic [pdlu_pkg::REM_W-1:0] cur_r;
  logic                       at_end;
  logic                       emit;
  logic [pdlu_pkg::REM_W:0]   r_sum;
  logic                       carry;
  logic [pdlu_pkg::REM_W:0]   r_step;
  pdlu_pkg::step_t            q_next;
  logic [16:0]                interp_val;
  pdlu_pkg::sample_t          beat_sample;
  logic                       beat_run_last;
  logic                       beat_packet_end;

  always_comb begin
    cur_phase = started ? phase : (head.interp ? PH_INTERP : PH_COPY);
    cur_cnt   = started ? cnt : '0;
    cur_q     = started ? q : pdlu_pkg::step_t'({head.held[15], head.held});
    cur_r     = started ? r : '0;
    at_end    = (cur_cnt == CW'(UPSAMPLE_RATIO - 1));
    emit      = ~empty & (~out_valid | ~out_stall);
    pop       = emit & at_end & ((cur_phase == PH_COPY) | ~head.last);

    r_sum  = {1'b0, cur_r} + {1'b0, head.step_r};
    carry  = (r_sum >= RATIO_C);
    r_step = carry ? (r_sum - RATIO_C) : r_sum;
    q_next = cur_q + head.step_q + pdlu_pkg::step_t'({16'b0, carry});

    interp_val = cur_q + {16'b0, cur_q[16] & (cur_r != '0)};

    case (cur_phase)
      PH_INTERP: begin
        beat_sample     = pdlu_pkg::sample_t'(interp_val[15:0]);
        beat_run_last   = at_end & ~head.last;
        beat_packet_end = 1'b0;
      end
      PH_COPY: begin
        beat_sample     = head.mono;
        beat_run_last   = at_end;
        beat_packet_end = at_end;
      end
      default: begin
        beat_sample     = head.mono;
        beat_run_last   = 1'b0;
        beat_packet_end = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started   <= 1'b0;
      phase     <= PH_INTERP;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (emit) begin
        out_valid  <= 1'b1;
        out_sample <= beat_sample;
        run_last   <= beat_run_last;
        packet_end <= beat_packet_end;
        if (pop) begin
          started <= 1'b0;
        end else if (at_end) begin
          started <= 1'b1;
          phase   <= PH_COPY;
          cnt     <= '0;
        end else begin
          started <= 1'b1;
          phase   <= cur_phase;
          cnt     <= cur_cnt + CW'(1);
          q       <= q_next;
          r       <= r_step[pdlu_pkg::REM_W-1:0];
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/pdlu_checker.sv =====
// Port-level checker for the PCM downmix linear upsampler, bound to the top level.
// Depends on pcm_downmix_linear_upsampler_unit_macros.svh for the assertion macros.
`include "pcm_downmix_linear_upsampler_unit_macros.svh"

module pdlu_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        packet_last,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_sample,
  input logic        run_last,
  input logic        packet_end
);

  logic       held;
  logic [7:0] pending;
  logic       in_beat;
  logic       run_beat;
  logic       opens_run;

  assign in_beat   = in_valid & ~in_stall;
  assign run_beat  = out_valid & ~out_stall & run_last;
  assign opens_run = in_beat & (held | packet_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      held    <= 1'b0;
      pending <= '0;
    end else begin
      if (in_beat) begin
        held <= ~packet_last;
      end
      if (opens_run && !run_beat) begin
        pending <= pending + 8'd1;
      end else if (run_beat && !opens_run) begin
        pending <= pending - 8'd1;
      end
    end
  end

  `PDLU_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sample) && $stable(run_last) && $stable(packet_end), "stalled output beat changed")
  `PDLU_ASSERT_IMPL(a_end_closes_run, out_valid && packet_end, run_last, "packet end without run end")
  `PDLU_ASSERT_IMPL(a_run_has_source, run_beat, pending != 8'd0 || opens_run, "run ended with no frame to cause it")

endmodule

bind pcm_downmix_linear_upsampler_unit pdlu_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .packet_last (packet_last),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .out_sample  (out_sample),
  .run_last    (run_last),
  .packet_end  (packet_end)
);
